FILE: hw/rtl/psu_pkg.sv
package psu_pkg;

	localparam int MAX_ROW_BYTES   = 8192;
	localparam int MAX_PIXEL_BYTES = 8;

	localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
	localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
	localparam int PIX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	localparam int ROW_BYTES_W = 14;
	localparam int BPP_W       = 4;
	localparam int CFG_W       = ROW_BYTES_W;

	typedef enum logic [0:0] {
		CFG_ROW_BYTES = 1'b0,
		CFG_BPP       = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_kind_t;

	// operands of one byte reconstruction
	typedef struct packed {
		filter_kind_t kind;
		logic [7:0]   x;
		logic [7:0]   a;
		logic [7:0]   b;
		logic [7:0]   c;
	} pred_t;

endpackage

FILE: hw/rtl/psu_stream_if.sv
interface psu_filt_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       frame_start;

	modport source (output valid, output in_byte, output frame_start, input ready);
	modport sink (input valid, input in_byte, input frame_start, output ready);
endinterface

interface psu_recon_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       row_end;
	logic       bad_filter;

	modport source (output valid, output out_byte, output row_end, output bad_filter,
		input ready);
	modport sink (input valid, input out_byte, input row_end, input bad_filter,
		output ready);
endinterface

FILE: hw/rtl/png_scanline_unfilter.sv
// PNG scanline filter reconstruction (none, sub, up, average, Paeth).
// filt carries the inflated stream one byte per item: a filter type byte
// (frame_start marks the first row of an image) followed by row_bytes data
// bytes. recon returns one item per data byte, row_end on the last byte of a
// row. A filter type above 4 returns one item with bad_filter set and all
// later bytes are dropped until the next frame_start.
// Throughput: one byte per cycle, data and filter bytes alike. A data byte
// reads the line store when accepted, then is reconstructed and written back
// in the reconstruct stage, which loads the output register that drives recon.
// Filter bytes of types 0 to 4 and dropped bytes give no item.
// The previous row lives in a single-port-read, single-port-write line store
// of MAX_ROW_BYTES bytes; a row reads each address after the previous row
// wrote it, so no forwarding is needed.
// Reset: row_bytes and bytes_per_pixel go to 1, the block awaits a filter
// byte of a first row, the line store is not cleared.
// When recon stalls, one item waits in the output register and one in the
// reconstruct stage; filt.ready drops only when both are full. The user
// writes config (cfg_we, cfg_index, cfg_data) only while idle (not enforced).
module png_scanline_unfilter
	import psu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	psu_filt_if.sink         filt,
	psu_recon_if.source      recon,
	input  logic             cfg_we,
	input  cfg_reg_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic [BPP_W-1:0]       bpp_q;

	logic [POS_W-1:0] pos_q;
	filter_kind_t     kind_q;
	logic             first_q;
	logic             err_q;

	logic [7:0] line_mem [MAX_ROW_BYTES];
	logic [7:0] rd_q;

	logic [7:0] left_q   [MAX_PIXEL_BYTES];
	logic [7:0] upleft_q [MAX_PIXEL_BYTES];

	logic              s1_v_q;
	logic [7:0]        x_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              aok_s1;
	logic              first_s1;
	filter_kind_t      kind_s1;
	logic              last_s1;
	logic              bad_s1;
	logic [PIX_W-1:0]  bidx_s1;

	logic       o_v_q;
	logic [7:0] o_byte_q;
	logic       o_end_q;
	logic       o_bad_q;

	// stage 0
	logic [POS_W-1:0]  rb_eff, pos_cur, pos_d;
	logic [PIX_W-1:0]  bidx;
	logic [ADDR_W-1:0] addr;
	logic              first_cur, first_d, err_cur, err_d;
	logic              is_data, is_bad, last;
	filter_kind_t      kind_d;
	logic              acc, s1_go, s1_load;

	// stage 1
	pred_t      pred;
	logic [7:0] r;

	assign s1_go     = s1_v_q && (!o_v_q || recon.ready);
	assign filt.ready = !s1_v_q || !o_v_q || recon.ready;
	assign acc       = filt.valid && filt.ready;

	always_comb begin
		if (row_bytes_q == '0) begin
			rb_eff = POS_W'(1);
		end else if (POS_W'(row_bytes_q) > POS_W'(MAX_ROW_BYTES)) begin
			rb_eff = POS_W'(MAX_ROW_BYTES);
		end else begin
			rb_eff = POS_W'(row_bytes_q);
		end
		if (bpp_q == '0) begin
			bidx = '0;
		end else if (bpp_q > BPP_W'(MAX_PIXEL_BYTES)) begin
			bidx = PIX_W'(MAX_PIXEL_BYTES - 1);
		end else begin
			bidx = PIX_W'(bpp_q - 4'd1);
		end

		pos_cur   = filt.frame_start ? '0 : pos_q;
		first_cur = filt.frame_start ? 1'b1 : first_q;
		err_cur   = filt.frame_start ? 1'b0 : err_q;

		addr    = ADDR_W'(pos_cur - POS_W'(1));
		last    = pos_cur >= rb_eff;
		is_data = 1'b0;
		is_bad  = 1'b0;
		pos_d   = pos_cur;
		first_d = first_cur;
		err_d   = err_cur;
		kind_d  = kind_q;

		if (!err_cur) begin
			if (pos_cur == '0) begin
				if (filt.in_byte > 8'(FILT_PAETH)) begin
					is_bad = 1'b1;
					err_d  = 1'b1;
				end else begin
					kind_d = filter_kind_t'(filt.in_byte[2:0]);
					pos_d  = POS_W'(1);
				end
			end else begin
				is_data = 1'b1;
				if (last) begin
					pos_d   = '0;
					first_d = 1'b0;
				end else begin
					pos_d = pos_cur + POS_W'(1);
				end
			end
		end
	end

	assign s1_load = acc && (is_data || is_bad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_W'(1);
			bpp_q       <= BPP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_BYTES: row_bytes_q <= cfg_data[ROW_BYTES_W-1:0];
				CFG_BPP:       bpp_q <= cfg_data[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			kind_q  <= FILT_NONE;
			first_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (acc) begin
			pos_q   <= pos_d;
			kind_q  <= kind_d;
			first_q <= first_d;
			err_q   <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_data) begin
			rd_q <= line_mem[addr];
		end
		if (s1_go && !bad_s1) begin
			line_mem[addr_s1] <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_load) begin
			s1_v_q <= 1'b1;
		end else if (s1_go) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			x_s1     <= filt.in_byte;
			addr_s1  <= addr;
			aok_s1   <= addr > ADDR_W'(bidx);
			first_s1 <= first_cur;
			kind_s1  <= kind_q;
			last_s1  <= last;
			bad_s1   <= is_bad;
			bidx_s1  <= bidx;
		end
	end

	always_comb begin
		pred.kind = kind_s1;
		pred.x    = x_s1;
		pred.a    = aok_s1 ? left_q[bidx_s1] : 8'd0;
		pred.b    = first_s1 ? 8'd0 : rd_q;
		pred.c    = (aok_s1 && !first_s1) ? upleft_q[bidx_s1] : 8'd0;
	end

	psu_predict u_predict (
		.p (pred),
		.r (r)
	);

	// newest byte at index 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
				left_q[k]   <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else if (s1_go && !bad_s1) begin
			for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
				left_q[k]   <= left_q[k-1];
				upleft_q[k] <= upleft_q[k-1];
			end
			left_q[0]   <= r;
			upleft_q[0] <= pred.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (s1_go) begin
			o_v_q <= 1'b1;
		end else if (recon.ready) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			o_byte_q <= bad_s1 ? 8'd0 : r;
			o_end_q  <= bad_s1 ? 1'b0 : last_s1;
			o_bad_q  <= bad_s1;
		end
	end

	assign recon.valid      = o_v_q;
	assign recon.out_byte   = o_byte_q;
	assign recon.row_end    = o_end_q;
	assign recon.bad_filter = o_bad_q;

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_ROW_BYTES))
		else $error("byte position past maximum row length");

	a_err_latch: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !filt.frame_start && !err_q && pos_q == '0 &&
		filt.in_byte > 8'(FILT_PAETH) |=> err_q && s1_v_q && bad_s1)
		else $error("bad filter byte did not latch error");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		acc && err_q && !filt.frame_start |=> !s1_v_q)
		else $error("byte after error reached reconstruct stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !s1_go |=> s1_v_q && $stable(addr_s1) && $stable(x_s1))
		else $error("stalled reconstruct stage lost its item");

	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		recon.valid && recon.bad_filter |-> recon.out_byte == 8'd0 && !recon.row_end)
		else $error("error item carries data");
`endif

endmodule

FILE: hw/rtl/psu_predict.sv
module psu_predict
	import psu_pkg::*;
(
	input  pred_t      p,
	output logic [7:0] r
);

	logic [9:0] pa, pb, pc, ab, c2;
	logic [8:0] sum_ab;
	logic [7:0] paeth, pred;

	always_comb begin
		sum_ab = {1'b0, p.a} + {1'b0, p.b};
		ab     = {1'b0, sum_ab};
		c2     = {1'b0, p.c, 1'b0};
		pa     = (p.b >= p.c) ? 10'(p.b - p.c) : 10'(p.c - p.b);
		pb     = (p.a >= p.c) ? 10'(p.a - p.c) : 10'(p.c - p.a);
		pc     = (ab >= c2) ? (ab - c2) : (c2 - ab);
		// ties go to left, then above
		if (pa <= pb && pa <= pc) begin
			paeth = p.a;
		end else if (pb <= pc) begin
			paeth = p.b;
		end else begin
			paeth = p.c;
		end
		case (p.kind)
			FILT_SUB:   pred = p.a;
			FILT_UP:    pred = p.b;
			FILT_AVG:   pred = sum_ab[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = 8'd0;
		endcase
		r = p.x + pred;
	end

endmodule
